[rtl/evcps_pkg.sv]
// Shared types, constants and fixed tables of the charging pilot sequencer.
package evcps_pkg;

    localparam int NUM_STATES      = 8;
    localparam int STATE_W         = $clog2(NUM_STATES);
    localparam int NUM_TRANSITIONS = 23;
    localparam int COND_LEN        = 14;

    localparam int ADC_W   = 12;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Input operation codes, carried on s_tuser.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_EVAL  = 2'd1;
    localparam logic [1:0] OP_OPEN  = 2'd2;
    localparam logic [1:0] OP_CLOSE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_FAULT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REENTRY_LIMIT = 2'd3;

    // Action codes that drive the pilot PWM and the contactor.
    localparam logic [7:0] ACT_PWM_ONLY  = 8'hB1;
    localparam logic [7:0] ACT_PWM_RELAY = 8'hB2;
    localparam logic [7:0] ACT_ALL_OFF   = 8'hB3;
    localparam logic [7:0] ACT_RELAY_ONLY = 8'hB4;

    // Condition codes added on top of the level lookup.
    localparam logic [7:0] COND_SESSION_BASE = 8'hF0;
    localparam logic [7:0] COND_REENTRY      = 8'hF6;

    // Summary codes.
    localparam logic [2:0] SUM_OFF      = 3'd1;
    localparam logic [2:0] SUM_READY    = 3'd2;
    localparam logic [2:0] SUM_CHARGING = 3'd3;
    localparam logic [2:0] SUM_FAULT    = 3'd4;

    localparam logic [STATE_W-1:0] ST_FAULT    = STATE_W'(7);
    localparam logic [STATE_W-1:0] ST_CHARGING = STATE_W'(6);

    // Proximity classification thresholds.
    localparam logic [ADC_W-1:0] CC_HIGH = 12'd2900;
    localparam logic [ADC_W-1:0] CC_LOW  = 12'd600;

    localparam logic [15:0] TIMEOUT_MAIN_RST  = 16'd1000;
    localparam logic [15:0] TIMEOUT_FAULT_RST = 16'd10;
    localparam logic [31:0] SESSION_LIMIT_RST = 32'd600000;
    localparam logic [15:0] REENTRY_LIMIT_RST = 16'd10;

    typedef struct packed {
        logic [STATE_W-1:0] src;
        logic [7:0]         cond;
        logic [STATE_W-1:0] dst;
        logic [7:0]         act;
    } trans_t;

    typedef struct packed {
        logic       pwm;
        logic       relay;
        logic       cc;
        logic [2:0] cp;
        logic [7:0] code;
    } cond_t;

    typedef struct packed {
        logic [15:0] timeout_main;
        logic [15:0] timeout_fault;
        logic [31:0] session_limit;
        logic [15:0] reentry_limit;
    } cfg_t;

    typedef struct packed {
        logic               fired;
        logic [STATE_W-1:0] dst;
        logic [7:0]         act;
    } eval_res_t;

    localparam trans_t TRANS_TAB [NUM_TRANSITIONS] = '{
        '{3'd0, 8'h00, 3'd1, 8'h00}, '{3'd1, 8'hE1, 3'd2, 8'hB3},
        '{3'd1, 8'hE2, 3'd2, 8'hB3}, '{3'd1, 8'hE3, 3'd2, 8'hB3},
        '{3'd2, 8'hE2, 3'd3, 8'hB3}, '{3'd3, 8'hE3, 3'd2, 8'hB3},
        '{3'd2, 8'hE4, 3'd1, 8'hB3}, '{3'd2, 8'h02, 3'd5, 8'hB1},
        '{3'd3, 8'h03, 3'd6, 8'hB1}, '{3'd6, 8'hE5, 3'd3, 8'hB3},
        '{3'd6, 8'h06, 3'd6, 8'hB2}, '{3'd6, 8'hE6, 3'd5, 8'hB1},
        '{3'd6, 8'hEA, 3'd7, 8'hB3}, '{3'd5, 8'hE7, 3'd4, 8'hB1},
        '{3'd4, 8'hE8, 3'd1, 8'hB3}, '{3'd4, 8'hE9, 3'd5, 8'hB1},
        '{3'd5, 8'h05, 3'd2, 8'hB3}, '{3'd1, 8'hF1, 3'd7, 8'h00},
        '{3'd2, 8'hF2, 3'd7, 8'h00}, '{3'd3, 8'hF3, 3'd7, 8'h00},
        '{3'd4, 8'hF4, 3'd7, 8'h00}, '{3'd5, 8'hF5, 3'd7, 8'h00},
        '{3'd2, 8'hF6, 3'd7, 8'h00}
    };

    localparam cond_t COND_TAB [COND_LEN] = '{
        '{1'b0, 1'b0, 1'b1, 3'd1, 8'hE1}, '{1'b0, 1'b0, 1'b1, 3'd3, 8'hE2},
        '{1'b0, 1'b0, 1'b1, 3'd0, 8'h00}, '{1'b0, 1'b0, 1'b1, 3'd2, 8'hE3},
        '{1'b0, 1'b0, 1'b0, 3'd1, 8'hE4}, '{1'b0, 1'b0, 1'b0, 3'd2, 8'hE4},
        '{1'b0, 1'b0, 1'b0, 3'd3, 8'hE4}, '{1'b1, 1'b1, 1'b1, 3'd5, 8'hE6},
        '{1'b1, 1'b0, 1'b0, 3'd4, 8'hE7}, '{1'b1, 1'b0, 1'b0, 3'd5, 8'hE7},
        '{1'b1, 1'b0, 1'b0, 3'd6, 8'hE7}, '{1'b1, 1'b0, 1'b0, 3'd0, 8'h00},
        '{1'b1, 1'b0, 1'b1, 3'd5, 8'hE9}, '{1'b1, 1'b1, 1'b0, 3'd4, 8'hEA}
    };

endpackage

[rtl/evcps_eval.sv]
// Evaluate logic: sample classification, condition gathering and transition lookup.
module evcps_eval (
    input  logic [evcps_pkg::STATE_W-1:0] cur_state,
    input  logic                          drive_pwm,
    input  logic                          drive_relay,
    input  logic [evcps_pkg::ADC_W-1:0]   adc_sample,
    input  logic [31:0]                   dwell_cur,
    input  logic [31:0]                   last_seen_cur,
    input  logic [31:0]                   first_entry_one,
    input  logic [15:0]                   entry_count_two,
    input  evcps_pkg::cfg_t               cfg,
    output evcps_pkg::eval_res_t          res
);

    logic        cc;
    logic [2:0]  cp;
    logic        cond_hit;
    logic [7:0]  cond_code;
    logic [15:0] limit;
    logic        timeout_hit;
    logic        session_hit;
    logic        reentry_hit;
    logic [31:0] session_span;
    logic [7:0]  session_code;
    logic [7:0]  state_code;

    always_comb begin
        logic [evcps_pkg::ADC_W-1:0] x;
        x = adc_sample;
        cc = (x < evcps_pkg::CC_HIGH) && (x > evcps_pkg::CC_LOW);
        cp = 3'd0;
        if (!drive_pwm) begin
            if (x > 12'd3000 && x < 12'd3430) begin
                cp = 3'd1;
            end else if (x > 12'd2500 && x < 12'd2900) begin
                cp = 3'd2;
            end else if (x > 12'd1500 && x < 12'd2000) begin
                cp = 3'd3;
            end
        end else begin
            if (x > 12'd2700 && x < 12'd3000) begin
                cp = 3'd4;
            end else if (x > 12'd2350 && x < 12'd2500) begin
                cp = 3'd5;
            end else if (x > 12'd1400 && x < 12'd1700) begin
                cp = 3'd6;
            end
        end
    end

    // Only the first matching level entry contributes a condition.
    always_comb begin
        cond_hit  = 1'b0;
        cond_code = 8'h00;
        for (int i = evcps_pkg::COND_LEN - 1; i >= 0; i--) begin
            if (drive_pwm == evcps_pkg::COND_TAB[i].pwm &&
                drive_relay == evcps_pkg::COND_TAB[i].relay &&
                cc == evcps_pkg::COND_TAB[i].cc &&
                cp == evcps_pkg::COND_TAB[i].cp) begin
                cond_hit  = 1'b1;
                cond_code = evcps_pkg::COND_TAB[i].code;
            end
        end
    end

    assign limit        = (cur_state == evcps_pkg::ST_FAULT) ? cfg.timeout_fault
                                                             : cfg.timeout_main;
    assign timeout_hit  = dwell_cur >= {16'd0, limit};
    assign session_span = last_seen_cur - first_entry_one;
    assign session_hit  = (cur_state >= evcps_pkg::STATE_W'(1)) &&
                          (cur_state <= evcps_pkg::STATE_W'(5)) &&
                          (session_span > cfg.session_limit);
    assign reentry_hit  = (cur_state == evcps_pkg::STATE_W'(2)) &&
                          (entry_count_two > cfg.reentry_limit);
    assign state_code   = 8'(cur_state);
    assign session_code = evcps_pkg::COND_SESSION_BASE | state_code;

    // First table entry from the active state whose condition is raised wins.
    always_comb begin
        logic [7:0] c;
        logic       raised;
        res = '0;
        for (int i = evcps_pkg::NUM_TRANSITIONS - 1; i >= 0; i--) begin
            c = evcps_pkg::TRANS_TAB[i].cond;
            raised = (cond_hit && c == cond_code) ||
                     (timeout_hit && c == state_code) ||
                     (session_hit && c == session_code) ||
                     (reentry_hit && c == evcps_pkg::COND_REENTRY);
            if (evcps_pkg::TRANS_TAB[i].src == cur_state && raised) begin
                res.fired = 1'b1;
                res.dst   = evcps_pkg::TRANS_TAB[i].dst;
                res.act   = evcps_pkg::TRANS_TAB[i].act;
            end
        end
    end

endmodule

[rtl/ev_charge_pilot_sequencer_top.sv]
// Top level of the AC charging control pilot sequencer.
//
// Input channel (s_*): one transfer per item. s_tuser carries the operation
// (tick, evaluate, open, close) and s_tdata the 12-bit pilot ADC sample.
// Result channel (m_*): exactly one result transfer per input item, in order.
// Configuration channel (cfg_*): cfg_index selects one of four registers
// (main timeout, fault timeout, session limit, re-entry limit) and cfg_data
// carries the value; it is always ready and should be written while idle.
//
// An item is captured in the input register, processed by the evaluate and
// bookkeeping logic, and its result is registered in the result register.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single pass between the input register and the result register.
// After reset the sequencer is closed in state 0 with all drives low and the
// registers at their defaults. When the receiver stalls, the result register
// holds; the input register then fills and s_tready drops until m_tready.
module ev_charge_pilot_sequencer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [evcps_pkg::S_TDATA_W-1:0]     s_tdata,   // [11:0] adc_sample
    input  logic [1:0]                          s_tuser,   // [1:0] opcode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] active_state, [5:3] summary_state, [6] pwm_enable,
    // [7] relay_close, [8] fired, [16:9] action_code
    output logic [evcps_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [evcps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [evcps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SW = evcps_pkg::STATE_W;
    localparam int NS = evcps_pkg::NUM_STATES;

    // Input register.
    logic                          in_valid_reg;
    logic [1:0]                    in_op_reg;
    logic [evcps_pkg::ADC_W-1:0]   in_adc_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [evcps_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    // Sequencer state.
    evcps_pkg::cfg_t cfg_reg;
    logic          enabled_reg, enabled_next;
    logic [SW-1:0] state_reg, state_next;
    logic          changed_reg, changed_next;
    logic [31:0]   time_base_reg, time_base_next;
    logic          pwm_reg, pwm_next;
    logic          relay_reg, relay_next;
    logic [31:0]   dwell_reg [NS];
    logic [31:0]   dwell_next [NS];
    logic [15:0]   entry_reg [NS];
    logic [15:0]   entry_next [NS];
    logic [31:0]   first_reg [NS];
    logic [31:0]   first_next [NS];
    logic [31:0]   last_reg [NS];
    logic [31:0]   last_next [NS];

    logic advance;
    logic process;
    logic fired;
    logic [7:0] act;
    logic [2:0] summary;
    evcps_pkg::eval_res_t eval_res;

    assign advance   = !out_valid_reg || m_tready;
    assign process   = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    evcps_eval u_eval (
        .cur_state      (state_reg),
        .drive_pwm      (pwm_reg),
        .drive_relay    (relay_reg),
        .adc_sample     (in_adc_reg),
        .dwell_cur      (dwell_reg[state_reg]),
        .last_seen_cur  (last_reg[state_reg]),
        .first_entry_one(first_reg[1]),
        .entry_count_two(entry_reg[2]),
        .cfg            (cfg_reg),
        .res            (eval_res)
    );

    always_comb begin
        enabled_next   = enabled_reg;
        state_next     = state_reg;
        changed_next   = changed_reg;
        time_base_next = time_base_reg;
        pwm_next       = pwm_reg;
        relay_next     = relay_reg;
        dwell_next     = dwell_reg;
        entry_next     = entry_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        fired          = 1'b0;
        act            = 8'h00;

        case (in_op_reg)
            evcps_pkg::OP_TICK: begin
                if (enabled_reg) begin
                    time_base_next = time_base_reg + 32'd1;
                    if (changed_reg) begin
                        // Entering a new state: restart its dwell time.
                        dwell_next[state_reg] = 32'd1;
                        if (entry_reg[state_reg] != 16'hFFFF) begin
                            entry_next[state_reg] = entry_reg[state_reg] + 16'd1;
                        end
                        if (first_reg[state_reg] == 32'd0) begin
                            first_next[state_reg] = time_base_next;
                        end
                        changed_next = 1'b0;
                    end else begin
                        dwell_next[state_reg] = dwell_reg[state_reg] + 32'd1;
                    end
                    last_next[state_reg] = time_base_next;
                end
            end
            evcps_pkg::OP_EVAL: begin
                if (enabled_reg && eval_res.fired) begin
                    fired        = 1'b1;
                    act          = eval_res.act;
                    state_next   = eval_res.dst;
                    changed_next = 1'b1;
                    case (eval_res.act)
                        evcps_pkg::ACT_PWM_ONLY: begin
                            pwm_next = 1'b1; relay_next = 1'b0;
                        end
                        evcps_pkg::ACT_PWM_RELAY: begin
                            pwm_next = 1'b1; relay_next = 1'b1;
                        end
                        evcps_pkg::ACT_ALL_OFF: begin
                            pwm_next = 1'b0; relay_next = 1'b0;
                        end
                        evcps_pkg::ACT_RELAY_ONLY: begin
                            pwm_next = 1'b0; relay_next = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                // Open and close both clear the session; the changed flag stays.
                enabled_next   = (in_op_reg == evcps_pkg::OP_OPEN);
                state_next     = '0;
                time_base_next = 32'd0;
                pwm_next       = 1'b0;
                relay_next     = 1'b0;
                for (int i = 0; i < NS; i++) begin
                    dwell_next[i] = 32'd0;
                    entry_next[i] = 16'd0;
                    first_next[i] = 32'd0;
                    last_next[i]  = 32'd0;
                end
            end
        endcase

        if (!enabled_next) begin
            summary = evcps_pkg::SUM_OFF;
        end else if (state_next == evcps_pkg::ST_FAULT) begin
            summary = evcps_pkg::SUM_FAULT;
        end else if (state_next == evcps_pkg::ST_CHARGING) begin
            summary = evcps_pkg::SUM_CHARGING;
        end else begin
            summary = evcps_pkg::SUM_READY;
        end

        out_data_next = {7'd0, act, fired, relay_next, pwm_next, summary, 3'(state_next)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.timeout_main  <= evcps_pkg::TIMEOUT_MAIN_RST;
            cfg_reg.timeout_fault <= evcps_pkg::TIMEOUT_FAULT_RST;
            cfg_reg.session_limit <= evcps_pkg::SESSION_LIMIT_RST;
            cfg_reg.reentry_limit <= evcps_pkg::REENTRY_LIMIT_RST;
            enabled_reg   <= 1'b0;
            state_reg     <= '0;
            changed_reg   <= 1'b0;
            time_base_reg <= 32'd0;
            pwm_reg       <= 1'b0;
            relay_reg     <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                dwell_reg[i] <= 32'd0;
                entry_reg[i] <= 16'd0;
                first_reg[i] <= 32'd0;
                last_reg[i]  <= 32'd0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (process) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    evcps_pkg::CFG_TIMEOUT_MAIN:  cfg_reg.timeout_main  <= cfg_data[15:0];
                    evcps_pkg::CFG_TIMEOUT_FAULT: cfg_reg.timeout_fault <= cfg_data[15:0];
                    evcps_pkg::CFG_SESSION_LIMIT: cfg_reg.session_limit <= cfg_data;
                    evcps_pkg::CFG_REENTRY_LIMIT: cfg_reg.reentry_limit <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (process) begin
                enabled_reg   <= enabled_next;
                state_reg     <= state_next;
                changed_reg   <= changed_next;
                time_base_reg <= time_base_next;
                pwm_reg       <= pwm_next;
                relay_reg     <= relay_next;
                dwell_reg     <= dwell_next;
                entry_reg     <= entry_next;
                first_reg     <= first_next;
                last_reg      <= last_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg  <= s_tuser;
            in_adc_reg <= s_tdata[evcps_pkg::ADC_W-1:0];
        end
        if (process) begin
            out_data_reg <= out_data_next;
        end
    end

    // A closed sequencer sits in state 0 with both drives released.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !enabled_reg |-> (state_reg == '0 && !pwm_reg && !relay_reg))
        else $error("closed sequencer holds a live state or drive");

    // A fired transition leaves an entry pending for the next tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (process && in_op_reg == evcps_pkg::OP_EVAL && enabled_reg && eval_res.fired)
        |=> changed_reg)
        else $error("fired transition did not mark a state change");

    // An empty result register must never block the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

endmodule
